/* design/sse_pkg.sv */
// Shared types and constants for the stepper encoder supervisor.
// Used by sse_cfg, sse_position, sse_supervise and stepper_encoder_supervisor.
package sse_pkg;

    // Encoder and drive geometry
    localparam int unsigned SAMPLE_W      = 14;
    localparam int unsigned SPR_W         = 17;
    localparam logic [SPR_W-1:0] MOTOR_STEPS_PER_TURN = 17'd3200;
    localparam logic signed [SAMPLE_W:0] HALF_SCALE     = 15'sd8192;
    localparam logic signed [SAMPLE_W:0] NEG_HALF_SCALE = -15'sd8192;
    localparam logic signed [33:0] LIMIT_INSET = 34'sd200;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_USER_MIN_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_MAX_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREEWHEEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIMEOUT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEALTH_RETRY   = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_USER_MIN_LIMIT = 32'h8000_0001;
    localparam logic [31:0] RST_USER_MAX_LIMIT = 32'h7FFF_FFFF;
    localparam logic [15:0] RST_RECOVERY_SPEED = 16'd1000;
    localparam logic [15:0] RST_STUCK_TIMEOUT  = 16'd500;
    localparam logic [15:0] RST_HEALTH_RETRY   = 16'd10000;

    typedef struct packed {
        logic [31:0] user_min_limit;
        logic [31:0] user_max_limit;
        logic [15:0] recovery_speed;
        logic        freewheel_after_move;
        logic [15:0] stuck_timeout_ms;
        logic [15:0] health_retry_ms;
    } cfg_t;

    // Turn tracking result for one request
    typedef struct packed {
        logic [31:0] turn_count;
        logic [31:0] turn_steps;
        logic [31:0] position;
    } track_t;

    // Supervision result for one request
    typedef struct packed {
        logic        healthy;
        logic        sync_request;
        logic        move_request;
        logic [31:0] move_target;
        logic [15:0] move_speed;
        logic        release_drive;
        logic        recovery_active;
        logic [SAMPLE_W-1:0] ref_sample;
        logic [31:0] ref_time;
        logic        was_enabled;
        logic        recovery;
    } sup_t;

endpackage

/* design/sse_cfg.sv */
// Configuration register file for the stepper encoder supervisor.
// Depends on sse_pkg.
module sse_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output sse_pkg::cfg_t                  cfg
);

    sse_pkg::cfg_t cfg_reg;
    sse_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                sse_pkg::REG_USER_MIN_LIMIT: cfg_next.user_min_limit = cfg_data;
                sse_pkg::REG_USER_MAX_LIMIT: cfg_next.user_max_limit = cfg_data;
                sse_pkg::REG_RECOVERY_SPEED: cfg_next.recovery_speed = cfg_data[15:0];
                sse_pkg::REG_FREEWHEEL:      cfg_next.freewheel_after_move = cfg_data[0];
                sse_pkg::REG_STUCK_TIMEOUT:  cfg_next.stuck_timeout_ms = cfg_data[15:0];
                sse_pkg::REG_HEALTH_RETRY:   cfg_next.health_retry_ms = cfg_data[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.user_min_limit       <= sse_pkg::RST_USER_MIN_LIMIT;
            cfg_reg.user_max_limit       <= sse_pkg::RST_USER_MAX_LIMIT;
            cfg_reg.recovery_speed       <= sse_pkg::RST_RECOVERY_SPEED;
            cfg_reg.freewheel_after_move <= 1'b0;
            cfg_reg.stuck_timeout_ms     <= sse_pkg::RST_STUCK_TIMEOUT;
            cfg_reg.health_retry_ms      <= sse_pkg::RST_HEALTH_RETRY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/sse_position.sv */
// Turn counting and multi-turn step position for one encoder sample.
// Depends on sse_pkg; purely combinational.
module sse_position (
    input  logic [sse_pkg::SAMPLE_W-1:0] sample,
    input  logic [sse_pkg::SAMPLE_W-1:0] prev_sample,
    input  logic [31:0]                  turn_count,
    input  logic [31:0]                  turn_steps,
    output sse_pkg::track_t              track
);

    logic signed [sse_pkg::SAMPLE_W:0]        delta;
    logic [sse_pkg::SAMPLE_W+sse_pkg::SPR_W-1:0] frac_prod;
    logic [sse_pkg::SPR_W-1:0]                frac_steps;
    logic                                     frac_rem;
    logic                                     round_up;
    logic [31:0]                              turn_next;
    logic [31:0]                              steps_next;
    logic [31:0]                              pos_sum;

    // Detect a half-scale wrap and step the turn count and its step offset
    assign delta = $signed({1'b0, sample}) - $signed({1'b0, prev_sample});

    always_comb
    begin
        turn_next  = turn_count;
        steps_next = turn_steps;
        if (delta > sse_pkg::HALF_SCALE)
        begin
            turn_next  = turn_count - 32'd1;
            steps_next = turn_steps
                       - {{(32-sse_pkg::SPR_W){1'b0}}, sse_pkg::MOTOR_STEPS_PER_TURN};
        end
        else if (delta < sse_pkg::NEG_HALF_SCALE)
        begin
            turn_next  = turn_count + 32'd1;
            steps_next = turn_steps
                       + {{(32-sse_pkg::SPR_W){1'b0}}, sse_pkg::MOTOR_STEPS_PER_TURN};
        end
    end

    // Scale the in-turn sample; round toward zero when the turn count is negative
    assign frac_prod  = {{sse_pkg::SPR_W{1'b0}}, sample} *
                        {{sse_pkg::SAMPLE_W{1'b0}}, sse_pkg::MOTOR_STEPS_PER_TURN};
    assign frac_steps = frac_prod[sse_pkg::SAMPLE_W+sse_pkg::SPR_W-1:sse_pkg::SAMPLE_W];
    assign frac_rem   = |frac_prod[sse_pkg::SAMPLE_W-1:0];
    assign round_up   = turn_next[31] & frac_rem;

    assign pos_sum = steps_next
                   + {{(32-sse_pkg::SPR_W){1'b0}}, frac_steps}
                   + {31'd0, round_up};

    assign track = '{turn_count: turn_next, turn_steps: steps_next, position: pos_sum};

endmodule

/* design/sse_supervise.sv */
// Encoder health check, enable sync and soft limit recovery decisions.
// Depends on sse_pkg; purely combinational.
module sse_supervise (
    input  logic [sse_pkg::SAMPLE_W-1:0] sample,
    input  logic [31:0]                  now_ms,
    input  logic                         motor_moving,
    input  logic                         motor_enabled,
    input  logic                         no_distance_left,
    input  logic [31:0]                  position,
    input  logic [sse_pkg::SAMPLE_W-1:0] ref_sample,
    input  logic [31:0]                  ref_time,
    input  logic                         was_enabled,
    input  logic                         recovery,
    input  sse_pkg::cfg_t                cfg,
    output sse_pkg::sup_t                sup
);

    logic [31:0]        elapsed;
    logic               stuck_check;
    logic               healthy;
    logic signed [33:0] pos_s;
    logic signed [33:0] min_l;
    logic signed [33:0] max_l;
    logic signed [33:0] min_target;
    logic signed [33:0] max_target;
    logic               below;
    logic               above;

    // Health: a zero sample fails; an unchanged sample while moving times out
    assign elapsed     = now_ms - ref_time;
    assign stuck_check = motor_moving && (sample == ref_sample);
    assign healthy     = (sample != '0) &&
                         (!stuck_check || (elapsed <= {16'd0, cfg.stuck_timeout_ms}));

    // Soft limits are the negated user limits, kept exact in 34 bits
    assign pos_s      = {{2{position[31]}}, position};
    assign min_l      = -$signed({{2{cfg.user_max_limit[31]}}, cfg.user_max_limit});
    assign max_l      = -$signed({{2{cfg.user_min_limit[31]}}, cfg.user_min_limit});
    assign min_target = min_l + sse_pkg::LIMIT_INSET;
    assign max_target = max_l - sse_pkg::LIMIT_INSET;
    assign below      = pos_s < min_l;
    assign above      = pos_s > max_l;

    always_comb
    begin
        sup = '0;
        sup.ref_sample  = ref_sample;
        sup.ref_time    = ref_time;
        sup.was_enabled = was_enabled;
        sup.recovery    = recovery;
        sup.healthy     = healthy;
        if (healthy)
        begin
            // Re-stamp the reference unless the stuck check is running
            if (!stuck_check)
            begin
                sup.ref_sample = sample;
                sup.ref_time   = now_ms;
            end
            sup.sync_request = motor_enabled && !was_enabled && no_distance_left;
            sup.was_enabled  = motor_enabled;
            if (!motor_enabled)
            begin
                if (below)
                begin
                    sup.move_request = 1'b1;
                    sup.move_target  = min_target[31:0];
                    sup.recovery     = 1'b1;
                end
                else if (above)
                begin
                    sup.move_request = 1'b1;
                    sup.move_target  = max_target[31:0];
                    sup.recovery     = 1'b1;
                end
            end
            else if (recovery && !motor_moving)
            begin
                // Stopped: end the recovery, release if back inside and freewheel is set
                sup.recovery      = 1'b0;
                sup.release_drive = !below && !above && cfg.freewheel_after_move;
            end
            if (sup.move_request)
            begin
                sup.move_speed = cfg.recovery_speed;
            end
            sup.recovery_active = sup.recovery;
        end
        else
        begin
            // Unhealthy: retry re-stamp only
            if (elapsed > {16'd0, cfg.health_retry_ms})
            begin
                sup.ref_time = now_ms;
            end
        end
    end

endmodule

/* design/stepper_encoder_supervisor.sv */
// Stepper encoder supervisor top level: input register, tick logic, result register.
// Depends on sse_pkg, sse_cfg, sse_position and sse_supervise.
// Flow: an accepted request waits in the input register until the result register
// slot frees. Throughput: one request per cycle while out_stall is low; the tick logic
// sits between the input and result registers, all tracking state updated in one pass.
// Reset: asynchronous active low; control and tracking state clear at once,
// configuration returns to its defaults, and the first request re-initializes tracking.
module stepper_encoder_supervisor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [sse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [13:0]                    encoder_sample,
    input  logic [31:0]                    now_ms,
    input  logic                           motor_moving,
    input  logic                           motor_enabled,
    input  logic                           no_distance_left,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             position_steps,
    output logic                           healthy,
    output logic                           sync_request,
    output logic                           move_request,
    output logic signed [31:0]             move_target,
    output logic [15:0]                    move_speed,
    output logic                           release_drive,
    output logic                           limit_recovery_active
);

    sse_pkg::cfg_t   cfg;
    sse_pkg::track_t track;
    sse_pkg::sup_t   sup;

    // Input register
    logic                          in_valid_reg;
    logic [sse_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [31:0]                   now_reg;
    logic                          moving_reg;
    logic                          enabled_reg;
    logic                          no_dist_reg;

    // Tracking state
    logic                          started_reg;
    logic [31:0]                   turn_reg;
    logic [31:0]                   turn_steps_reg;
    logic [sse_pkg::SAMPLE_W-1:0]  prev_reg;
    logic [sse_pkg::SAMPLE_W-1:0]  ref_sample_reg;
    logic [31:0]                   ref_time_reg;
    logic                          was_enabled_reg;
    logic                          recovery_reg;

    // Result register
    logic                          out_valid_reg;
    logic [31:0]                   position_reg;
    logic                          healthy_reg;
    logic                          sync_reg;
    logic                          move_reg;
    logic [31:0]                   target_reg;
    logic [15:0]                   speed_reg;
    logic                          release_reg;
    logic                          active_reg;

    logic                          advance;
    logic                          fire;
    logic                          in_accept;

    // First request initializes the tracking from its own sample and time
    logic [31:0]                   turn_eff;
    logic [31:0]                   turn_steps_eff;
    logic [sse_pkg::SAMPLE_W-1:0]  prev_eff;
    logic [sse_pkg::SAMPLE_W-1:0]  ref_sample_eff;
    logic [31:0]                   ref_time_eff;

    assign turn_eff       = started_reg ? turn_reg       : 32'd0;
    assign turn_steps_eff = started_reg ? turn_steps_reg : 32'd0;
    assign prev_eff       = started_reg ? prev_reg       : sample_reg;
    assign ref_sample_eff = started_reg ? ref_sample_reg : sample_reg;
    assign ref_time_eff   = started_reg ? ref_time_reg   : now_reg;

    sse_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sse_position u_position (
        .sample      (sample_reg),
        .prev_sample (prev_eff),
        .turn_count  (turn_eff),
        .turn_steps  (turn_steps_eff),
        .track       (track)
    );

    sse_supervise u_supervise (
        .sample           (sample_reg),
        .now_ms           (now_reg),
        .motor_moving     (moving_reg),
        .motor_enabled    (enabled_reg),
        .no_distance_left (no_dist_reg),
        .position         (track.position),
        .ref_sample       (ref_sample_eff),
        .ref_time         (ref_time_eff),
        .was_enabled      (was_enabled_reg),
        .recovery         (recovery_reg),
        .cfg              (cfg),
        .sup              (sup)
    );

    // Pipeline flow: the result slot frees when empty or being taken
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Hold the input request until it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg  <= encoder_sample;
            now_reg     <= now_ms;
            moving_reg  <= motor_moving;
            enabled_reg <= motor_enabled;
            no_dist_reg <= no_distance_left;
        end
    end

    // Advance the tracking state once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            turn_reg        <= '0;
            turn_steps_reg  <= '0;
            prev_reg        <= '0;
            ref_sample_reg  <= '0;
            ref_time_reg    <= '0;
            was_enabled_reg <= 1'b0;
            recovery_reg    <= 1'b0;
        end
        else if (fire)
        begin
            started_reg     <= 1'b1;
            turn_reg        <= track.turn_count;
            turn_steps_reg  <= track.turn_steps;
            prev_reg        <= sample_reg;
            ref_sample_reg  <= sup.ref_sample;
            ref_time_reg    <= sup.ref_time;
            was_enabled_reg <= sup.was_enabled;
            recovery_reg    <= sup.recovery;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            position_reg <= track.position;
            healthy_reg  <= sup.healthy;
            sync_reg     <= sup.sync_request;
            move_reg     <= sup.move_request;
            target_reg   <= sup.move_target;
            speed_reg    <= sup.move_speed;
            release_reg  <= sup.release_drive;
            active_reg   <= sup.recovery_active;
        end
    end

    assign out_valid             = out_valid_reg;
    assign position_steps        = $signed(position_reg);
    assign healthy               = healthy_reg;
    assign sync_request          = sync_reg;
    assign move_request          = move_reg;
    assign move_target           = $signed(target_reg);
    assign move_speed            = speed_reg;
    assign release_drive         = release_reg;
    assign limit_recovery_active = active_reg;

endmodule

/* sim/tb_stepper_encoder_supervisor.sv */
// Testbench for stepper_encoder_supervisor: directed and random control ticks with an
// in-bench predictor of turn tracking, encoder health and soft limit recovery.
// Depends on sse_pkg and the stepper_encoder_supervisor RTL.
module tb_stepper_encoder_supervisor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COUNTS_PER_TURN = 64'sd1 << sse_pkg::SAMPLE_W;
    localparam int     DRAIN_CYCLES    = 8;
    localparam int     LIMIT_CYCLES    = 900000;
    localparam int     TICKS_PER_PHASE = 250;
    localparam int     RANDOM_PHASES   = 8;

    typedef struct {
        logic [13:0] code;
        logic [31:0] now;
        logic        moving;
        logic        enabled;
        logic        no_dist;
    } tick_t;

    typedef struct {
        logic signed [31:0] position_steps;
        logic               healthy;
        logic               sync_request;
        logic               move_request;
        logic signed [31:0] move_target;
        logic [15:0]        move_speed;
        logic               release_drive;
        logic               limit_recovery_active;
    } report_t;

    // Block ports
    logic                          clk;
    logic                          rst_n            = 1'b0;
    logic                          cfg_write        = 1'b0;
    logic [sse_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
    logic [31:0]                   cfg_data         = '0;
    logic                          in_valid         = 1'b0;
    logic                          in_stall;
    logic [13:0]                   encoder_sample   = '0;
    logic [31:0]                   now_ms           = '0;
    logic                          motor_moving     = 1'b0;
    logic                          motor_enabled    = 1'b0;
    logic                          no_distance_left = 1'b0;
    logic                          out_valid;
    logic                          out_stall        = 1'b0;
    logic signed [31:0]            position_steps;
    logic                          healthy;
    logic                          sync_request;
    logic                          move_request;
    logic signed [31:0]            move_target;
    logic [15:0]                   move_speed;
    logic                          release_drive;
    logic                          limit_recovery_active;

    // Pending ticks and predicted reports
    tick_t   pending_ticks[$];
    report_t expected_reports[$];

    // Configuration copy
    logic signed [31:0] cfg_min_limit = sse_pkg::RST_USER_MIN_LIMIT;
    logic signed [31:0] cfg_max_limit = sse_pkg::RST_USER_MAX_LIMIT;
    logic [15:0]        cfg_speed     = sse_pkg::RST_RECOVERY_SPEED;
    logic               cfg_freewheel = 1'b0;
    logic [15:0]        cfg_stuck     = sse_pkg::RST_STUCK_TIMEOUT;
    logic [15:0]        cfg_retry     = sse_pkg::RST_HEALTH_RETRY;

    // Tracking state copy
    logic [31:0]   trk_turns     = '0;
    logic [13:0]   trk_prev      = '0;
    logic [31:0]   trk_position  = '0;
    logic [13:0]   ref_code      = '0;
    logic [31:0]   ref_time      = '0;
    logic          enc_healthy   = 1'b1;
    logic          drive_was_on  = 1'b0;
    logic          recovering    = 1'b0;
    logic          tracking_live = 1'b0;

    // Handshake pacing
    int send_gap      = 0;
    int send_stretch  = 0;
    bit send_quiet    = 1'b0;
    int rcv_gap       = 0;
    int rcv_stretch   = 0;
    bit rcv_quiet     = 1'b0;
    int hold_left     = 0;
    bit pressure_done = 1'b0;
    int results_seen  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    stepper_encoder_supervisor dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the report that one accepted tick must produce
    task automatic predict_report(input tick_t t);
        int          delta;
        longint      counts;
        longint      pos;
        longint      lo_lim;
        longint      hi_lim;
        longint      tgt;
        logic [31:0] elapsed;
        logic        sync;
        logic        move;
        logic        rel;
        report_t     r;
        r    = '{default: '0};
        sync = 1'b0;
        move = 1'b0;
        rel  = 1'b0;
        tgt  = 0;

        // seed tracking from the first request
        if (!tracking_live)
        begin
            tracking_live = 1'b1;
            enc_healthy   = (t.code != '0);
            trk_prev      = t.code;
            ref_code      = t.code;
            ref_time      = t.now;
            trk_turns     = '0;
        end

        // count turns on half-scale jumps
        delta = int'(t.code) - int'(trk_prev);
        if (delta > int'(sse_pkg::HALF_SCALE))
            trk_turns = trk_turns - 32'd1;
        else if (delta < int'(sse_pkg::NEG_HALF_SCALE))
            trk_turns = trk_turns + 32'd1;
        trk_prev = t.code;

        counts       = longint'($signed(trk_turns)) * COUNTS_PER_TURN + longint'(t.code);
        pos          = (counts * longint'(sse_pkg::MOTOR_STEPS_PER_TURN)) / COUNTS_PER_TURN;
        trk_position = pos[31:0];
        pos          = longint'($signed(trk_position));

        // health: zero code fails, a frozen code while moving fails after the timeout
        if (t.code == '0)
            enc_healthy = 1'b0;
        else if (t.moving && t.code == ref_code)
        begin
            elapsed     = t.now - ref_time;
            enc_healthy = (elapsed <= {16'd0, cfg_stuck});
        end
        else
        begin
            ref_code    = t.code;
            ref_time    = t.now;
            enc_healthy = 1'b1;
        end

        r.position_steps = trk_position;
        if (!enc_healthy)
        begin
            // re-stamp once the retry period has run out
            elapsed = t.now - ref_time;
            if (elapsed > {16'd0, cfg_retry})
                ref_time = t.now;
        end
        else
        begin
            sync         = t.enabled && !drive_was_on && t.no_dist;
            drive_was_on = t.enabled;
            lo_lim       = -longint'(cfg_max_limit);
            hi_lim       = -longint'(cfg_min_limit);
            if (!t.enabled)
            begin
                if (pos < lo_lim)
                begin
                    tgt        = lo_lim + longint'(sse_pkg::LIMIT_INSET);
                    move       = 1'b1;
                    recovering = 1'b1;
                end
                else if (pos > hi_lim)
                begin
                    tgt        = hi_lim - longint'(sse_pkg::LIMIT_INSET);
                    move       = 1'b1;
                    recovering = 1'b1;
                end
            end
            else if (recovering && !t.moving)
            begin
                recovering = 1'b0;
                if (pos >= lo_lim && pos <= hi_lim && cfg_freewheel)
                    rel = 1'b1;
            end
            r.healthy               = 1'b1;
            r.sync_request          = sync;
            r.move_request          = move;
            r.move_target           = move ? tgt[31:0] : '0;
            r.move_speed            = move ? cfg_speed : '0;
            r.release_drive         = rel;
            r.limit_recovery_active = recovering;
        end
        expected_reports.push_back(r);
    endtask

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_tick(input logic [13:0] code, input logic [31:0] now,
                            input logic mv, input logic en, input logic nd);
        tick_t t;
        t.code    = code;
        t.now     = now;
        t.moving  = mv;
        t.enabled = en;
        t.no_dist = nd;
        pending_ticks.push_back(t);
    endtask

    task automatic write_reg(input logic [sse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            sse_pkg::REG_USER_MIN_LIMIT: cfg_min_limit = data;
            sse_pkg::REG_USER_MAX_LIMIT: cfg_max_limit = data;
            sse_pkg::REG_RECOVERY_SPEED: cfg_speed     = data[15:0];
            sse_pkg::REG_FREEWHEEL:      cfg_freewheel = data[0];
            sse_pkg::REG_STUCK_TIMEOUT:  cfg_stuck     = data[15:0];
            sse_pkg::REG_HEALTH_RETRY:   cfg_retry     = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] min_lim, input logic [31:0] max_lim,
                              input logic [15:0] speed, input logic fw,
                              input logic [15:0] stuck, input logic [15:0] retry);
        write_reg(sse_pkg::REG_USER_MIN_LIMIT, min_lim);
        write_reg(sse_pkg::REG_USER_MAX_LIMIT, max_lim);
        write_reg(sse_pkg::REG_RECOVERY_SPEED, {16'd0, speed});
        write_reg(sse_pkg::REG_FREEWHEEL, {31'd0, fw});
        write_reg(sse_pkg::REG_STUCK_TIMEOUT, {16'd0, stuck});
        write_reg(sse_pkg::REG_HEALTH_RETRY, {16'd0, retry});
        @(posedge clk);
        cfg_write <= 1'b0;
        // queue the next ticks away from the clock edge
        @(negedge clk);
    endtask

    // Wait until every request is through and the block has settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_ticks.size() != 0 || expected_reports.size() != 0 || in_valid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sender: offer pending ticks, hold each until accepted
    always @(posedge clk or negedge rst_n)
    begin : sender
        bit took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                predict_report(pending_ticks.pop_front());
                send_gap = gap_len(send_quiet);
            end
            if (send_stretch == 0)
            begin
                send_stretch = $urandom_range(50, 300);
                send_quiet   = ($urandom_range(0, 3) == 0);
            end
            else
                send_stretch--;
            if (!in_valid || took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    in_valid         <= 1'b1;
                    encoder_sample   <= pending_ticks[0].code;
                    now_ms           <= pending_ticks[0].now;
                    motor_moving     <= pending_ticks[0].moving;
                    motor_enabled    <= pending_ticks[0].enabled;
                    no_distance_left <= pending_ticks[0].no_dist;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each accepted report, stall at random
    always @(posedge clk or negedge rst_n)
    begin : receiver
        report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rcv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report received with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("position_steps", want.position_steps, position_steps);
                    check_field("healthy", want.healthy, healthy);
                    check_field("sync_request", want.sync_request, sync_request);
                    check_field("move_request", want.move_request, move_request);
                    check_field("move_target", want.move_target, move_target);
                    check_field("move_speed", want.move_speed, move_speed);
                    check_field("release_drive", want.release_drive, release_drive);
                    check_field("limit_recovery_active", want.limit_recovery_active,
                                limit_recovery_active);
                end
                results_seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (!pressure_done && results_seen >= 600)
            begin
                hold_left     = 400;
                pressure_done = 1'b1;
            end
            if (rcv_stretch == 0)
            begin
                rcv_stretch = $urandom_range(50, 300);
                rcv_quiet   = ($urandom_range(0, 3) == 0);
            end
            else
                rcv_stretch--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                rcv_gap = ($urandom_range(0, 3) == 0) ? gap_len(rcv_quiet) : 0;
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          k;
        int          r;
        int          jump;
        int          nxt;
        int          lim_a;
        int          lim_b;
        int          gen_code;
        int          gen_drift;
        int          gen_turns;
        int          hold_run;
        logic [31:0] gen_now;
        bit          gen_en;
        bit          mv;
        bit          nd;
        logic [13:0] code;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: first request, wraps, stuck timeout, retry, time wrap
        add_tick(14'd0,     32'h0000_0000, 1'b0, 1'b0, 1'b0);
        add_tick(14'h3FFF,  32'hFFFF_FF00, 1'b0, 1'b1, 1'b1);
        add_tick(14'd1,     32'hFFFF_FF10, 1'b1, 1'b1, 1'b0);
        add_tick(14'h3FFF,  32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0);
        add_tick(14'h3FFF,  32'h0000_0100, 1'b1, 1'b1, 1'b0);
        add_tick(14'h3FFF,  32'h0000_0200, 1'b1, 1'b1, 1'b0);
        add_tick(14'h3FFF,  32'h0000_3000, 1'b1, 1'b1, 1'b0);
        add_tick(14'h3FFF,  32'h0000_3100, 1'b1, 1'b1, 1'b0);
        add_tick(14'h2000,  32'h0000_3101, 1'b0, 1'b0, 1'b0);
        add_tick(14'h2AAA,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
        add_tick(14'h1555,  32'h0000_0000, 1'b1, 1'b0, 1'b1);
        add_tick(14'h3FFF,  32'h0000_0001, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // Narrow window: recovery from above, recovery ending outside the window, zero timeouts
        set_config(-32'sd1000, 32'sd1000, 16'hFFFF, 1'b1, 16'd0, 16'd0);
        add_tick(14'd2000,  32'd100, 1'b0, 1'b0, 1'b0);
        add_tick(14'd3000,  32'd110, 1'b1, 1'b1, 1'b0);
        add_tick(14'd3000,  32'd120, 1'b0, 1'b1, 1'b0);
        add_tick(14'd9000,  32'd130, 1'b0, 1'b0, 1'b0);
        add_tick(14'd15000, 32'd140, 1'b1, 1'b0, 1'b0);
        add_tick(14'd15000, 32'd150, 1'b0, 1'b1, 1'b1);
        add_tick(14'd4000,  32'd160, 1'b1, 1'b1, 1'b0);
        add_tick(14'd10000, 32'd170, 1'b1, 1'b1, 1'b0);
        add_tick(14'd10000, 32'd171, 1'b1, 1'b1, 1'b0);
        add_tick(14'd10000, 32'd171, 1'b1, 1'b0, 1'b0);
        wait_idle();

        // Most negative limits: negation leaves the 32-bit range
        set_config(32'h8000_0000, 32'h8000_0000, 16'd1, 1'b0, 16'hFFFF, 16'hFFFF);
        add_tick(14'd10001, 32'd200, 1'b0, 1'b0, 1'b0);
        add_tick(14'd10002, 32'd210, 1'b0, 1'b1, 1'b0);
        wait_idle();

        gen_code  = $urandom_range(1, 16383);
        gen_now   = $urandom();
        gen_en    = 1'b0;
        gen_drift = 0;
        gen_turns = 0;
        hold_run  = 0;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            lim_a = $urandom_range(200, 15000);
            lim_b = $urandom_range(200, 15000);
            case (phase)
                0: set_config(-lim_a, lim_b, 16'($urandom_range(0, 65535)), 1'b1,
                              16'($urandom_range(100, 1500)), 16'($urandom_range(0, 4000)));
                1: set_config(-lim_a, lim_b, 16'($urandom_range(0, 65535)), 1'b0,
                              16'd0, 16'd0);
                2: set_config(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b1, 16'hFFFF, 16'hFFFF);
                3:
                begin
                    lim_a = int'($urandom_range(0, 6000)) - 3000;
                    set_config(lim_a, lim_a, 16'($urandom_range(0, 65535)), 1'b1,
                               16'($urandom_range(50, 800)), 16'($urandom_range(0, 2000)));
                end
                4: set_config(32'h7FFF_FFFF, 32'h8000_0001, 16'hFFFF, 1'b0,
                              16'($urandom_range(50, 800)), 16'($urandom_range(0, 2000)));
                default: set_config(-lim_a, lim_b, 16'($urandom_range(0, 65535)),
                                    1'($urandom_range(0, 1)), 16'($urandom_range(50, 2000)),
                                    16'($urandom_range(0, 20000)));
            endcase

            for (k = 0; k < TICKS_PER_PHASE; k++)
            begin
                r = $urandom_range(0, 99);
                if (hold_run > 0)
                begin
                    // frozen code while moving: runs into the stuck timeout
                    hold_run--;
                    code    = gen_code[13:0];
                    mv      = 1'b1;
                    gen_now = gen_now + $urandom_range(20, 300);
                end
                else if (r < 5)
                begin
                    hold_run = $urandom_range(2, 12);
                    code     = gen_code[13:0];
                    mv       = 1'b1;
                    gen_now  = gen_now + $urandom_range(0, 50);
                end
                else if (r < 9)
                begin
                    // communication fault
                    code    = '0;
                    mv      = 1'($urandom_range(0, 1));
                    gen_now = gen_now + $urandom_range(0, 3000);
                end
                else
                begin
                    if (r < 13)
                        jump = $urandom_range(0, 16383);
                    else
                        jump = int'($urandom_range(0, 2400)) - 1200 + gen_drift;
                    nxt = (gen_code + jump) & 32'h3FFF;
                    if (nxt == 0)
                        nxt = 1;
                    if (nxt - gen_code > 8192)
                        gen_turns--;
                    else if (nxt - gen_code < -8192)
                        gen_turns++;
                    gen_code = nxt;
                    code     = nxt[13:0];
                    mv       = ($urandom_range(0, 3) != 0);
                    r        = $urandom_range(0, 99);
                    if (r < 80)
                        gen_now = gen_now + $urandom_range(0, 40);
                    else if (r < 96)
                        gen_now = gen_now + $urandom_range(100, 1500);
                    else if (r < 99)
                        gen_now = gen_now + $urandom_range(5000, 70000);
                    else
                        gen_now = $urandom();
                end
                if ($urandom_range(0, 9) == 0)
                    gen_en = !gen_en;
                nd = mv ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) != 0);
                // steer the walk back toward the soft limit window
                if ($urandom_range(0, 29) == 0)
                begin
                    if (gen_turns > 2)
                        gen_drift = -int'($urandom_range(200, 1500));
                    else if (gen_turns < -2)
                        gen_drift = $urandom_range(200, 1500);
                    else
                        gen_drift = int'($urandom_range(0, 3000)) - 1500;
                end
                add_tick(code, gen_now, mv, gen_en, nd);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
